@@ rtl/cfe_pkg.sv @@
// ----------------------------------------------------------------------------
// cfe_pkg
// Shared types and constants of the color fade envelope block.
// ----------------------------------------------------------------------------
package cfe_pkg;

  localparam int unsigned COEF_BITS_DEF = 16;
  localparam int unsigned CHANNEL_BITS  = 8;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned TICKS_W    = 24;
  localparam int unsigned COLOR_W    = 32;
  localparam int unsigned OUT_CH_W   = CHANNEL_BITS;

  localparam logic [CFG_IDX_W-1:0] REG_START_TIME       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_TICKS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN_TICKS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_TICKS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_START_COLOR      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FINAL_COLOR      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RUN_BEFORE_START = 3'd6;

  localparam logic [TICKS_W-1:0] SUSTAIN_RESET     = 24'd1000000;
  localparam logic [COLOR_W-1:0] START_COLOR_RESET = 32'hFFFF_FFFF;

  localparam logic [1:0] PH_ATTACK  = 2'd0;
  localparam logic [1:0] PH_SUSTAIN = 2'd1;
  localparam logic [1:0] PH_RELEASE = 2'd2;
  localparam logic [1:0] PH_DONE    = 2'd3;

  localparam logic FUNC_FRAME   = 1'b0;
  localparam logic FUNC_TRIGGER = 1'b1;

  typedef struct packed {
    logic              func;
    logic [TIME_W-1:0] current_time;
  } cfe_in_t;

  typedef struct packed {
    logic                visible;
    logic [1:0]          phase;
    logic [OUT_CH_W-1:0] red;
    logic [OUT_CH_W-1:0] green;
    logic [OUT_CH_W-1:0] blue;
    logic [OUT_CH_W-1:0] alpha;
  } cfe_out_t;

  typedef struct packed {
    logic       load;
    logic       retrig;
    logic       eval;
    logic       sum_s;
    logic       classify;
    logic       div_step;
    logic       mix;
    logic [1:0] ch_idx;
    logic       push;
  } cfe_cmd_t;

  typedef struct packed {
    logic hidden;
    logic need_div;
  } cfe_stat_t;

endpackage

@@ rtl/cfe_ctrl.sv @@
// ----------------------------------------------------------------------------
// cfe_ctrl
// Sequencer of the color fade envelope: accepts one transaction at a time,
// steps the datapath through evaluation, division and mixing, and owns the
// output valid flag.
// ----------------------------------------------------------------------------
module cfe_ctrl #(
  parameter int unsigned COEF_BITS = cfe_pkg::COEF_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              in_func_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output cfe_pkg::cfe_cmd_t cmd_o,
  input  cfe_pkg::cfe_stat_t stat_i
);
  import cfe_pkg::*;

  localparam int unsigned DCW = $clog2(COEF_BITS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EVAL  = 3'd1;
  localparam logic [2:0] S_SUMS  = 3'd2;
  localparam logic [2:0] S_CLASS = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_MIX   = 3'd5;
  localparam logic [2:0] S_PUSH  = 3'd6;

  logic [2:0]     state_q, state_d;
  logic [DCW-1:0] dcnt_q, dcnt_d;
  logic [1:0]     ccnt_q, ccnt_d;
  logic           out_valid_q, out_valid_d;
  logic           accept;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    state_d     = state_q;
    dcnt_d      = dcnt_q;
    ccnt_d      = ccnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.ch_idx = ccnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_func_i == FUNC_TRIGGER) begin
            cmd_o.retrig = 1'b1;
          end else begin
            cmd_o.load = 1'b1;
            state_d    = S_EVAL;
          end
        end
      end
      S_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = stat_i.hidden ? S_PUSH : S_SUMS;
      end
      S_SUMS: begin
        cmd_o.sum_s = 1'b1;
        state_d     = S_CLASS;
      end
      S_CLASS: begin
        cmd_o.classify = 1'b1;
        dcnt_d         = '0;
        ccnt_d         = '0;
        state_d        = stat_i.need_div ? S_DIV : S_MIX;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        dcnt_d         = dcnt_q + 1'b1;
        if (dcnt_q == DCW'(COEF_BITS)) begin
          state_d = S_MIX;
        end
      end
      S_MIX: begin
        cmd_o.mix = 1'b1;
        ccnt_d    = ccnt_q + 1'b1;
        if (ccnt_q == 2'd3) begin
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.push  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      dcnt_q      <= '0;
      ccnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      dcnt_q      <= dcnt_d;
      ccnt_q      <= ccnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ rtl/cfe_datapath.sv @@
// ----------------------------------------------------------------------------
// cfe_datapath
// Configuration registers, envelope state, phase classification, a restoring
// divider for the blend coefficient, a one-multiplier channel mixer and the
// output register.
// ----------------------------------------------------------------------------
module cfe_datapath #(
  parameter int unsigned COEF_BITS    = cfe_pkg::COEF_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [cfe_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [cfe_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  cfe_pkg::cfe_in_t                    in_data_i,
  input  cfe_pkg::cfe_cmd_t                   cmd_i,
  output cfe_pkg::cfe_stat_t                  stat_o,
  output cfe_pkg::cfe_out_t                   out_data_o
);
  import cfe_pkg::*;

  localparam int unsigned REM_W = TICKS_W + 1;
  localparam int unsigned CF_W  = COEF_BITS + 1;
  localparam int unsigned MW    = CHANNEL_BITS + COEF_BITS + 4;
  localparam int unsigned SH0   = 3 * CHANNEL_BITS;
  localparam int unsigned SH1   = 2 * CHANNEL_BITS;
  localparam int unsigned SH2   = CHANNEL_BITS;

  logic [TICKS_W-1:0]  att_q, sus_q, rel_q;
  logic [COLOR_W-1:0]  scol_q, fcol_q;
  logic                rbs_q, started_q;
  logic [TIME_W-1:0]   origin_q, last_q, t_q;
  logic [TIME_W:0]     a_end_q;
  logic [TIME_W+1:0]   s_end_q;
  logic [REM_W-1:0]    rem_q;
  logic [TICKS_W-1:0]  den_q;
  logic [CF_W-1:0]     coef_q;
  logic [1:0]          phase_q;
  logic                vis_q;
  logic [OUT_CH_W-1:0] ch_q [4];
  cfe_out_t            out_q;

  logic [TIME_W-1:0]   orig_eff;
  logic                hidden;
  logic [TIME_W+2:0]   t_ext, r_end;
  logic                in_att, in_sus, in_rel, t_le_o;
  logic [TIME_W-1:0]   t_minus_o;
  logic [TIME_W+2:0]   r_minus_t;
  logic                div_ge;
  logic [REM_W-1:0]    div_diff;

  logic [CHANNEL_BITS-1:0]         s_ch, f_ch;
  logic signed [CHANNEL_BITS:0]    ch_diff;
  logic signed [COEF_BITS+1:0]     coef_s;
  logic signed [CHANNEL_BITS+COEF_BITS+2:0] prod;
  logic [MW-1:0]                   mix_v;
  logic [CHANNEL_BITS-1:0]         mix_ch;

  function automatic logic [CHANNEL_BITS-1:0] chan_of(input logic [COLOR_W-1:0] color,
                                                      input logic [1:0] idx);
    logic [2*COLOR_W-1:0] ext;
    logic [2*COLOR_W-1:0] sh;
    ext = {{COLOR_W{1'b0}}, color};
    unique case (idx)
      2'd0:    sh = ext >> SH0;
      2'd1:    sh = ext >> SH1;
      2'd2:    sh = ext >> SH2;
      default: sh = ext;
    endcase
    return sh[CHANNEL_BITS-1:0];
  endfunction

  assign orig_eff = started_q ? origin_q : t_q;
  assign hidden   = (t_q <= origin_q) && !rbs_q;

  assign t_ext     = {3'b000, t_q};
  assign r_end     = {1'b0, s_end_q} + (TIME_W + 3)'(rel_q);
  assign in_att    = t_ext <= {2'b00, a_end_q};
  assign in_sus    = t_ext <= {1'b0, s_end_q};
  assign in_rel    = t_ext <= r_end;
  assign t_le_o    = t_q <= origin_q;
  assign t_minus_o = t_q - origin_q;
  assign r_minus_t = r_end - t_ext;

  assign div_ge   = rem_q >= {1'b0, den_q};
  assign div_diff = div_ge ? (rem_q - {1'b0, den_q}) : rem_q;

  assign stat_o.hidden   = hidden;
  assign stat_o.need_div = (in_att && (att_q != '0) && !t_le_o) || (!in_att && !in_sus && in_rel);

  assign s_ch    = chan_of(scol_q, cmd_i.ch_idx);
  assign f_ch    = chan_of(fcol_q, cmd_i.ch_idx);
  assign ch_diff = $signed({1'b0, s_ch}) - $signed({1'b0, f_ch});
  assign coef_s  = $signed({1'b0, coef_q});
  assign prod    = ch_diff * coef_s;
  assign mix_v   = (MW'(f_ch) << COEF_BITS) + MW'(prod) + (MW'(1) << (COEF_BITS - 1));
  assign mix_ch  = mix_v[COEF_BITS +: CHANNEL_BITS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      att_q     <= '0;
      sus_q     <= SUSTAIN_RESET;
      rel_q     <= '0;
      scol_q    <= START_COLOR_RESET;
      fcol_q    <= '0;
      rbs_q     <= 1'b0;
      started_q <= 1'b0;
      origin_q  <= '0;
      last_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_START_TIME:       origin_q <= cfg_data_i[TIME_W-1:0];
          REG_ATTACK_TICKS:     att_q    <= cfg_data_i[TICKS_W-1:0];
          REG_SUSTAIN_TICKS:    sus_q    <= cfg_data_i[TICKS_W-1:0];
          REG_RELEASE_TICKS:    rel_q    <= cfg_data_i[TICKS_W-1:0];
          REG_START_COLOR:      scol_q   <= cfg_data_i[COLOR_W-1:0];
          REG_FINAL_COLOR:      fcol_q   <= cfg_data_i[COLOR_W-1:0];
          REG_RUN_BEFORE_START: rbs_q    <= cfg_data_i[0];
          default: ;
        endcase
      end else if (cmd_i.retrig) begin
        origin_q <= last_q;
      end else if (cmd_i.eval && !hidden) begin
        started_q <= 1'b1;
        origin_q  <= orig_eff;
      end
      if (cmd_i.load) begin
        last_q <= in_data_i.current_time;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      t_q <= in_data_i.current_time;
    end
    if (cmd_i.eval) begin
      a_end_q <= {1'b0, orig_eff} + (TIME_W + 1)'(att_q);
      vis_q   <= !hidden;
      phase_q <= PH_ATTACK;
      for (int i = 0; i < 4; i++) begin
        ch_q[i] <= '0;
      end
    end
    if (cmd_i.sum_s) begin
      s_end_q <= {1'b0, a_end_q} + (TIME_W + 2)'(sus_q);
    end
    if (cmd_i.classify) begin
      coef_q <= '0;
      if (in_att) begin
        phase_q <= PH_ATTACK;
        den_q   <= att_q;
        rem_q   <= REM_W'(t_minus_o);
        if (att_q == '0) begin
          coef_q <= CF_W'(1) << COEF_BITS;
        end
      end else if (in_sus) begin
        phase_q <= PH_SUSTAIN;
        coef_q  <= CF_W'(1) << COEF_BITS;
      end else if (in_rel) begin
        phase_q <= PH_RELEASE;
        den_q   <= rel_q;
        rem_q   <= REM_W'(r_minus_t);
      end else begin
        phase_q <= PH_DONE;
      end
    end
    if (cmd_i.div_step) begin
      rem_q  <= {div_diff[REM_W-2:0], 1'b0};
      coef_q <= {coef_q[CF_W-2:0], div_ge};
    end
    if (cmd_i.mix) begin
      ch_q[cmd_i.ch_idx] <= OUT_CH_W'(mix_ch);
    end
    if (cmd_i.push) begin
      out_q.visible <= vis_q;
      out_q.phase   <= phase_q;
      out_q.red     <= ch_q[0];
      out_q.green   <= ch_q[1];
      out_q.blue    <= ch_q[2];
      out_q.alpha   <= ch_q[3];
    end
  end

  assign out_data_o = out_q;

endmodule

@@ rtl/color_fade_envelope_top.sv @@
// ----------------------------------------------------------------------------
// color_fade_envelope_top
// Attack-sustain-release color fader with a linear crossfade between the
// final and start colors, driven by per-frame timestamps.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake              Payload
//  in       input      in_valid_i/in_ready_o  cfe_in_t (func, current_time)
//  out      output     out_valid_o/out_ready_i cfe_out_t (visible, phase, RGBA)
//  cfg      input      cfg_we_i               cfg_idx_i, cfg_data_i
//
//  A hidden frame goes from evaluation straight to its push; a shown frame
//  first sums the phase ends, classifies, divides when needed and mixes.
//  The restoring divider gives one quotient bit per cycle, the shared channel
//  multiplier one channel per cycle. A trigger transaction gives no result.
//  Reset is asynchronous and active low. A result waits in the output
//  register while out_ready_i is low; the next frame stalls only at its push.
// ----------------------------------------------------------------------------
module color_fade_envelope_top #(
  parameter int unsigned COEF_BITS    = cfe_pkg::COEF_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cfe_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cfe_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  cfe_pkg::cfe_in_t               in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output cfe_pkg::cfe_out_t              out_data_o
);
  import cfe_pkg::*;

  cfe_cmd_t  cmd;
  cfe_stat_t stat;

  cfe_ctrl #(
    .COEF_BITS(COEF_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_func_i   (in_data_i.func),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  cfe_datapath #(
    .COEF_BITS   (COEF_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_data_i  (in_data_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .out_data_o (out_data_o)
  );

  // A trigger transaction never produces a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_data_i.func == FUNC_TRIGGER) |=> !$rose(out_valid_o))
    else $error("result produced by a trigger transaction");

  // A frame transaction keeps the block busy on the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_data_i.func == FUNC_FRAME) |=> !in_ready_o)
    else $error("input accepted while a frame is in progress");

  // A hidden frame carries an all-zero payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.visible) |->
      (out_data_o.phase == PH_ATTACK && out_data_o.red == '0 && out_data_o.green == '0 &&
       out_data_o.blue == '0 && out_data_o.alpha == '0))
    else $error("hidden frame with nonzero payload");

  // Control commands are mutually exclusive.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.load, cmd.retrig, cmd.eval, cmd.sum_s, cmd.classify, cmd.div_step,
              cmd.mix, cmd.push}))
    else $error("more than one datapath command issued");

endmodule

@@ verif/color_fade_envelope_top_test.sv @@
// ----------------------------------------------------------------------------
// color_fade_envelope_top_test
// Self-checking testbench for the envelope color fader. A queue-fed driver
// sends frame and retrigger transactions, and a monitor compares every result
// with a cycle-free prediction of visibility, phase and the blended RGBA.
// Directed frames cover the phase boundaries, hidden frames, zero attack and
// frames before the origin. Random envelope sweeps follow under register
// settings that include the extremes, with random stalls on both channels.
// ----------------------------------------------------------------------------
module color_fade_envelope_top_test;
  import cfe_pkg::*;

  localparam int unsigned COEF = COEF_BITS_DEF;
  localparam logic [COEF:0] COEF_ONE = {1'b1, {COEF{1'b0}}};
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = COEF + 24;
  localparam int N_SETTINGS = 12;
  localparam int ITEMS_PER_SETTING = 155;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  cfe_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  cfe_out_t              out_data;

  color_fade_envelope_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  // Fader state as predicted.
  logic [TICKS_W-1:0] cfg_attack = '0;
  logic [TICKS_W-1:0] cfg_sustain = SUSTAIN_RESET;
  logic [TICKS_W-1:0] cfg_release = '0;
  logic [COLOR_W-1:0] cfg_start_color = START_COLOR_RESET;
  logic [COLOR_W-1:0] cfg_final_color = '0;
  logic               cfg_run_early = 1'b0;
  logic               env_started = 1'b0;
  logic [TIME_W-1:0]  env_origin = '0;
  logic [TIME_W-1:0]  prev_frame_time = '0;

  // Stimulus generator view of the envelope.
  logic [TIME_W-1:0] gen_origin = '0;
  logic [TIME_W-1:0] gen_last = '0;

  cfe_in_t  frame_queue[$];
  cfe_out_t expected_pixels[$];

  int  send_idle_pct = 0;
  int  recv_idle_pct = 0;
  bit  in_fire = 1'b0;
  int  cycle_count = 0;
  int  fail_count = 0;
  int  n_pushed = 0;
  int  n_triggers = 0;
  int  n_results = 0;
  int  n_settings = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [OUT_CH_W-1:0] mix_channel(input logic [7:0] s,
                                                      input logic [7:0] f,
                                                      input logic [COEF:0] coef);
    logic [COEF+9:0] acc;
    acc = s * coef + f * (COEF_ONE - coef) + (COEF_ONE >> 1);
    return acc[COEF+7:COEF];
  endfunction

  task automatic predict_pixel(input cfe_in_t item);
    cfe_out_t          pix;
    logic [33:0]       attack_end;
    logic [33:0]       sustain_end;
    logic [33:0]       release_end;
    logic [63:0]       quot;
    logic [COEF:0]     coef;
    logic [TIME_W-1:0] t;
    if (item.func == FUNC_TRIGGER) begin
      env_origin = prev_frame_time;
      return;
    end
    t = item.current_time;
    prev_frame_time = t;
    pix = '0;
    if (t <= env_origin && !cfg_run_early) begin
      expected_pixels.push_back(pix);
      return;
    end
    if (!env_started) begin
      env_started = 1'b1;
      env_origin = t;
    end
    attack_end = 34'(env_origin) + 34'(cfg_attack);
    sustain_end = attack_end + 34'(cfg_sustain);
    release_end = sustain_end + 34'(cfg_release);
    if (34'(t) <= attack_end) begin
      pix.phase = PH_ATTACK;
      if (cfg_attack == '0) begin
        coef = COEF_ONE;
      end else if (t <= env_origin) begin
        coef = '0;
      end else begin
        quot = (64'(t - env_origin) << COEF) / 64'(cfg_attack);
        coef = (quot > 64'(COEF_ONE)) ? COEF_ONE : quot[COEF:0];
      end
    end else if (34'(t) <= sustain_end) begin
      pix.phase = PH_SUSTAIN;
      coef = COEF_ONE;
    end else if (34'(t) <= release_end) begin
      pix.phase = PH_RELEASE;
      quot = (64'(release_end - 34'(t)) << COEF) / 64'(cfg_release);
      coef = (quot > 64'(COEF_ONE)) ? COEF_ONE : quot[COEF:0];
    end else begin
      pix.phase = PH_DONE;
      coef = '0;
    end
    pix.visible = 1'b1;
    pix.red   = mix_channel(cfg_start_color[31:24], cfg_final_color[31:24], coef);
    pix.green = mix_channel(cfg_start_color[23:16], cfg_final_color[23:16], coef);
    pix.blue  = mix_channel(cfg_start_color[15:8], cfg_final_color[15:8], coef);
    pix.alpha = mix_channel(cfg_start_color[7:0], cfg_final_color[7:0], coef);
    expected_pixels.push_back(pix);
  endtask

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Acceptance, prediction and result checking on the rising edge.
  always @(posedge clk_i) begin
    cfe_out_t want;
    in_fire = rst_ni && in_valid && in_ready;
    if (in_fire) begin
      predict_pixel(in_data);
    end
    if (rst_ni && out_valid && out_ready) begin
      n_results++;
      if (expected_pixels.size() == 0) begin
        $error("result transaction with no expectation pending");
        fail_count++;
      end else begin
        want = expected_pixels.pop_front();
        check_field("visible", want.visible, out_data.visible);
        check_field("phase", want.phase, out_data.phase);
        check_field("red", want.red, out_data.red);
        check_field("green", want.green, out_data.green);
        check_field("blue", want.blue, out_data.blue);
        check_field("alpha", want.alpha, out_data.alpha);
      end
    end
  end

  // Driver: new inputs on the falling edge.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid || in_fire) begin
        if (frame_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= frame_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("color_fade_envelope_top_test failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    case (idx)
      REG_START_TIME: begin
        env_origin = val;
        gen_origin = val;
      end
      REG_ATTACK_TICKS: cfg_attack = val[TICKS_W-1:0];
      REG_SUSTAIN_TICKS: cfg_sustain = val[TICKS_W-1:0];
      REG_RELEASE_TICKS: cfg_release = val[TICKS_W-1:0];
      REG_START_COLOR: cfg_start_color = val;
      REG_FINAL_COLOR: cfg_final_color = val;
      REG_RUN_BEFORE_START: cfg_run_early = val[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic push_frame(input logic [TIME_W-1:0] t);
    frame_queue.push_back(cfe_in_t'{func: FUNC_FRAME, current_time: t});
    gen_last = t;
    n_pushed++;
  endtask

  task automatic push_trigger(input logic [TIME_W-1:0] t);
    frame_queue.push_back(cfe_in_t'{func: FUNC_TRIGGER, current_time: t});
    gen_origin = gen_last;
    n_pushed++;
    n_triggers++;
  endtask

  task automatic wait_drained();
    while (frame_queue.size() != 0 || in_valid || expected_pixels.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  function automatic logic [TICKS_W-1:0] pick_ticks();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return TICKS_W'($urandom_range(1, 3));
      default: return TICKS_W'($urandom_range(1, 3000));
    endcase
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  task automatic apply_random_setting(input int k);
    logic [TICKS_W-1:0] a;
    logic [TICKS_W-1:0] s;
    logic [TICKS_W-1:0] r;
    a = pick_ticks();
    s = pick_ticks();
    r = pick_ticks();
    if (k == 0) begin
      a = '1;
      s = '0;
      r = '1;
    end else if (k == 1) begin
      a = '0;
      s = '1;
      r = '0;
    end else if (k == 2) begin
      a = '0;
      s = '0;
      r = '0;
    end
    write_reg(REG_ATTACK_TICKS, {8'($urandom()), a});
    write_reg(REG_SUSTAIN_TICKS, {8'($urandom()), s});
    write_reg(REG_RELEASE_TICKS, {8'($urandom()), r});
    write_reg(REG_START_COLOR, pick_word());
    write_reg(REG_FINAL_COLOR, pick_word());
    write_reg(REG_RUN_BEFORE_START, $urandom());
    write_reg(REG_START_TIME, pick_word());
    if ($urandom_range(0, 1)) begin
      write_reg(REG_UNUSED, $urandom());
    end
    n_settings++;
  endtask

  // A retrigger followed by frames around the attack, sustain and release edges.
  task automatic push_sweep();
    logic [63:0] a_end;
    logic [63:0] s_end;
    logic [63:0] r_end;
    logic [63:0] t;
    int          n;
    push_trigger($urandom());
    a_end = 64'(gen_origin) + 64'(cfg_attack);
    s_end = a_end + 64'(cfg_sustain);
    r_end = s_end + 64'(cfg_release);
    n = $urandom_range(3, 10);
    repeat (n) begin
      case ($urandom_range(0, 7))
        0: t = 64'(gen_origin) + $urandom_range(0, 1);
        1: t = a_end;
        2: t = a_end + 1;
        3: t = s_end;
        4: t = s_end + 1;
        5: t = r_end;
        6: t = r_end + 1;
        default: t = 64'(gen_origin) + $urandom_range(0, 32'(r_end - 64'(gen_origin)) + 2);
      endcase
      push_frame(t[TIME_W-1:0]);
    end
  endtask

  task automatic push_random_items(input int count);
    int kind;
    int target;
    target = n_pushed + count;
    while (n_pushed < target) begin
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        push_sweep();
      end else if (kind == 7) begin
        push_frame($urandom());
      end else if (kind == 8) begin
        push_trigger($urandom());
      end else begin
        push_frame(gen_origin - $urandom_range(0, 40));
      end
    end
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  initial begin
    set_idling(22, 82);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset settings: the first shown frame latches the origin with zero attack.
    push_frame(32'd0);
    push_frame(32'd7);
    push_frame(32'd8);
    push_frame(32'd1000007);
    push_frame(32'd1000008);
    wait_drained();

    write_reg(REG_ATTACK_TICKS, 32'd100);
    write_reg(REG_SUSTAIN_TICKS, 32'd50);
    write_reg(REG_RELEASE_TICKS, 32'd200);
    write_reg(REG_START_COLOR, 32'hFF00_FF7F);
    write_reg(REG_FINAL_COLOR, 32'h00FF_0080);
    write_reg(REG_RUN_BEFORE_START, 32'd0);
    write_reg(REG_START_TIME, 32'd1000);
    write_reg(REG_UNUSED, 32'hDEAD_BEEF);
    push_frame(32'd1000);
    push_frame(32'd1001);
    push_frame(32'd1050);
    push_frame(32'd1100);
    push_frame(32'd1101);
    push_frame(32'd1150);
    push_frame(32'd1151);
    push_frame(32'd1349);
    push_frame(32'd1350);
    push_frame(32'd1351);
    push_frame(32'hFFFF_FFFF);
    push_trigger(32'hFFFF_FFFF);
    push_frame(32'hFFFF_FFFF);
    push_frame(32'd5);
    wait_drained();

    // Running ahead of the origin, with zero and with full-length attack.
    write_reg(REG_RUN_BEFORE_START, 32'd1);
    write_reg(REG_ATTACK_TICKS, 32'd0);
    write_reg(REG_START_TIME, 32'd500);
    push_frame(32'd400);
    push_frame(32'd500);
    wait_drained();
    write_reg(REG_ATTACK_TICKS, 32'h00FF_FFFF);
    write_reg(REG_START_TIME, 32'd500);
    push_frame(32'd400);
    wait_drained();

    for (int k = 0; k < N_SETTINGS; k++) begin
      if (k == N_SETTINGS / 3) begin
        set_idling(82, 22);
      end else if (k == 2 * N_SETTINGS / 3) begin
        set_idling(0, 0);
      end
      apply_random_setting(k);
      push_random_items(ITEMS_PER_SETTING);
      wait_drained();
    end

    $display("Sent %0d transactions (%0d retriggers), checked %0d results.",
             n_pushed, n_triggers, n_results);
    $display("Covered %0d random register settings plus directed phase edges.",
             n_settings);
    if (fail_count == 0) begin
      $display("color_fade_envelope_top_test passed");
    end else begin
      $display("color_fade_envelope_top_test failed");
    end
    $finish;
  end

endmodule
